FILE: rtl/hptd_pkg.sv
// Shared types and constants for the header/payload/trailer deframer.
// Used by hptd_core and header_payload_trailer_deframer; no dependencies.
`default_nettype none

package hptd_pkg;

  localparam int unsigned PayloadLength = 5;
  localparam int unsigned MaxMarkLength = 4;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned PatternW      = 32;
  localparam int unsigned MarkBytes     = PatternW / ByteW;
  localparam int unsigned LengthW       = 3;
  localparam int unsigned PayloadW      = 40;
  localparam int unsigned CountW        = 16;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = PatternW;

  localparam int unsigned PosMax = (PayloadLength > MaxMarkLength) ? PayloadLength
                                                                   : MaxMarkLength;
  localparam int unsigned PosW   = $clog2(PosMax + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_PATTERN  = 2'd0,
    CFG_HEADER_LENGTH   = 2'd1,
    CFG_TRAILER_PATTERN = 2'd2,
    CFG_TRAILER_LENGTH  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_TRAILER = 3'b100
  } phase_e;

  typedef struct packed {
    logic [PatternW-1:0] header_pattern;
    logic [LengthW-1:0]  header_length;
    logic [PatternW-1:0] trailer_pattern;
    logic [LengthW-1:0]  trailer_length;
  } cfg_t;

  typedef struct packed {
    logic                frame_complete;
    logic [PayloadW-1:0] payload_bytes;
    logic [CountW-1:0]   retry_count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/hptd_core.sv
// Deframer state machine: phase, position, payload capture and retry counter.
// Result is combinational from the current state and the byte; state advances on step_i.
// Depends on hptd_pkg.
`default_nettype none

module hptd_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire logic [7:0]              rx_byte_i,
  input  wire hptd_pkg::cfg_t          cfg_i,
  output hptd_pkg::result_t            result_o
);
  import hptd_pkg::*;

  localparam int unsigned MarkIdxW  = (MarkBytes > 1) ? $clog2(MarkBytes) : 1;
  localparam int unsigned PackBytes = (PayloadLength < PayloadW / ByteW) ? PayloadLength
                                                                         : PayloadW / ByteW;

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [PayloadLength-1:0][ByteW-1:0] store_q;

  logic [MarkBytes-1:0][ByteW-1:0] mark_pat;
  logic [LengthW-1:0] mark_len_raw;
  logic [PosW-1:0]    mark_len;
  logic [ByteW-1:0]   mark_byte;
  logic [PosW:0]      pos_inc;
  logic               is_trailer;
  logic               complete;
  logic [PayloadW-1:0] packed_payload;

  // Length zero acts as one, anything above the limit acts as the limit.
  function automatic logic [PosW-1:0] eff_length(input logic [LengthW-1:0] len);
    logic [PosW-1:0] res;
    if (len == '0) begin
      res = PosW'(1);
    end else if (int'(len) > int'(MaxMarkLength)) begin
      res = PosW'(MaxMarkLength);
    end else begin
      res = PosW'(len);
    end
    return res;
  endfunction

  assign is_trailer   = (phase_q == PH_TRAILER);
  assign mark_pat     = is_trailer ? cfg_i.trailer_pattern : cfg_i.header_pattern;
  assign mark_len_raw = is_trailer ? cfg_i.trailer_length : cfg_i.header_length;
  assign mark_len     = eff_length(mark_len_raw);
  assign mark_byte    = (int'(pos_q) < int'(MarkBytes)) ? mark_pat[pos_q[MarkIdxW-1:0]]
                                                        : '0;
  assign pos_inc      = {1'b0, pos_q} + (PosW+1)'(1);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    complete = 1'b0;
    case (phase_q)
      PH_PAYLOAD: begin
        if (int'(pos_inc) >= int'(PayloadLength)) begin
          pos_d   = '0;
          phase_d = PH_TRAILER;
          cnt_d   = '0;
        end else begin
          pos_d = pos_inc[PosW-1:0];
        end
      end
      default: begin
        // header, trailer and unused codes share the marker compare
        if (rx_byte_i != mark_byte) begin
          phase_d = PH_HEADER;
          pos_d   = '0;
          cnt_d   = cnt_q + CountW'(1);
        end else if (pos_inc >= {1'b0, mark_len}) begin
          pos_d = '0;
          if (is_trailer) begin
            phase_d  = PH_HEADER;
            cnt_d    = '0;
            complete = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end else begin
          pos_d   = pos_inc[PosW-1:0];
          phase_d = is_trailer ? PH_TRAILER : PH_HEADER;
        end
      end
    endcase
  end

  always_comb begin
    packed_payload = '0;
    for (int i = 0; i < int'(PackBytes); i++) begin
      packed_payload[i*ByteW +: ByteW] = store_q[i];
    end
  end

  assign result_o.frame_complete = complete;
  assign result_o.payload_bytes  = complete ? packed_payload : '0;
  assign result_o.retry_count    = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  // capture payload bytes at their position
  for (genvar g = 0; g < int'(PayloadLength); g++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (step_i && phase_q == PH_PAYLOAD && int'(pos_q) == g) begin
        store_q[g] <= rx_byte_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_payload_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (int'(pos_q) < int'(PayloadLength)))
    else $error("payload position out of range");

  a_complete_from_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.frame_complete) |=> (phase_q == PH_HEADER && pos_q == '0
                                              && cnt_q == '0))
    else $error("frame completion did not restart the header search");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register is not one-hot");
`endif

endmodule

`default_nettype wire

FILE: rtl/header_payload_trailer_deframer.sv
// A result is registered in the output register, or in the skid entry if that
// is stalled; the whole state update is one registered step. One byte per cycle
// while in_stall_o is low; the skid entry takes a byte while a result waits.
// Reset (rst_ni low, asynchronous): header phase, position and retry counter zero,
// patterns zero, lengths one, output empty. Payload capture is not reset.
`default_nettype none

module header_payload_trailer_deframer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [hptd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [hptd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [7:0]                       rx_byte_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic                             frame_complete_o,
  output      logic [hptd_pkg::PayloadW-1:0]    payload_bytes_o,
  output      logic [hptd_pkg::CountW-1:0]      retry_count_o
);
  import hptd_pkg::*;

  cfg_t    cfg_q;
  result_t step_res;
  result_t main_q, skid_q;
  logic    main_valid_q, skid_valid_q;
  logic    in_xfer, main_free;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign main_free  = !main_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_pattern  <= '0;
      cfg_q.header_length   <= LengthW'(1);
      cfg_q.trailer_pattern <= '0;
      cfg_q.trailer_length  <= LengthW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_HEADER_PATTERN:  cfg_q.header_pattern  <= cfg_data_i[PatternW-1:0];
        CFG_HEADER_LENGTH:   cfg_q.header_length   <= cfg_data_i[LengthW-1:0];
        CFG_TRAILER_PATTERN: cfg_q.trailer_pattern <= cfg_data_i[PatternW-1:0];
        CFG_TRAILER_LENGTH:  cfg_q.trailer_length  <= cfg_data_i[LengthW-1:0];
        default: ;
      endcase
    end
  end

  hptd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_xfer),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_free) begin
      // drain the skid entry first to keep order
      main_valid_q <= skid_valid_q || in_xfer;
      skid_valid_q <= 1'b0;
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      main_q <= skid_valid_q ? skid_q : step_res;
    end else if (in_xfer) begin
      skid_q <= step_res;
    end
  end

  assign out_valid_o      = main_valid_q;
  assign frame_complete_o = main_q.frame_complete;
  assign payload_bytes_o  = main_q.payload_bytes;
  assign retry_count_o    = main_q.retry_count;

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held without an output entry");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && main_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("transfer under stalled output was not held in skid entry");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(main_q)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
